### design/assert_macros.svh
// Assertion macros shared by the register block modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset
`define UHCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included
`define UHCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/uhcr_pkg.sv
// Types, constants and register layout of the host controller register block
package uhcr_pkg;

    // Root ports and tick clamp
    localparam int NUM_PORTS       = 2;
    localparam int PORT_IW         = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [7:0] MAX_TICK_FRAMES = 8'd16;

    // Item kinds
    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_ATTACH = 3'd2;
    localparam logic [2:0] KIND_DETACH = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // Result codes
    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_RESET    = 2'd1;
    localparam logic [1:0] RC_BAD_PORT = 2'd2;

    // Access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;

    // Register offsets
    localparam logic [4:0] OFF_CMD     = 5'h00;
    localparam logic [4:0] OFF_STS     = 5'h02;
    localparam logic [4:0] OFF_INTR    = 5'h04;
    localparam logic [4:0] OFF_FRNUM   = 5'h06;
    localparam logic [4:0] OFF_FLBASE0 = 5'h08;
    localparam logic [4:0] OFF_FLBASE1 = 5'h0a;
    localparam logic [4:0] OFF_SOF     = 5'h0c;

    // Command bits
    localparam int CMD_RS      = 0;
    localparam int CMD_HCRESET = 1;
    localparam int CMD_GRESET  = 2;
    localparam int CMD_EGSM    = 3;
    localparam int CMD_FGR     = 4;

    // Status bits
    localparam int STS_USBINT = 0;
    localparam int STS_RD     = 2;
    localparam int STS_HALTED = 5;

    // Port control bits and masks
    localparam int PRT_CCS  = 0;
    localparam int PRT_CSC  = 1;
    localparam int PRT_EN   = 2;
    localparam int PRT_ENC  = 3;
    localparam int PRT_RD   = 6;
    localparam int PRT_LSDA = 8;
    localparam logic [15:0] PRT_READ_ONLY   = 16'h01bb;
    localparam logic [15:0] PRT_WRITE_CLEAR = 16'h000a;

    // Reset and fill values
    localparam logic [15:0] UNMAPPED_VALUE = 16'hff7f;
    localparam logic [15:0] STS_RESET      = 16'h0020;
    localparam logic [15:0] PORT_RESET     = 16'h0080;
    localparam logic [7:0]  SOF_RESET      = 8'd64;

    // One input item
    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  reg_offset;
        logic [1:0]  access_size;
        logic [15:0] write_data;
        logic        port_number;
        logic        low_speed;
        logic [7:0]  elapsed_frames;
    } t_item;

    // One result item
    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  result_code;
        logic        irq_pulse;
    } t_result;

endpackage

### design/uhcr_in_stage.sv
// Input register stage: holds one accepted item until the register file takes it
module uhcr_in_stage import uhcr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_adv,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/uhcr_regfile.sv
// Controller registers and the update logic for one item
module uhcr_regfile import uhcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_adv,
    input  t_item      i_item,
    output t_result    o_res
);

`include "assert_macros.svh"

    logic [7:0]  r_limit;
    logic [15:0] r_cmd,   n_cmd;
    logic [15:0] r_sts,   n_sts;
    logic        r_sts2,  n_sts2;
    logic [15:0] r_intr,  n_intr;
    logic [10:0] r_frnum, n_frnum;
    logic [31:12] r_flbase, n_flbase;
    logic [7:0]  r_sof,   n_sof;
    logic [15:0] r_port [NUM_PORTS];
    logic [15:0] n_port [NUM_PORTS];
    logic        r_pend,  n_pend;

    logic [15:0] wdata;
    logic [2:0]  reg_port;
    logic [2:0]  sel_port3;
    logic [PORT_IW-1:0] pidx;
    logic        reg_port_ok;
    logic        evt_port_ok;
    logic [15:0] pval;
    logic [15:0] pwr_v;
    logic [15:0] pwr_keep;
    logic        any_rd;
    logic [15:0] rd_val;
    logic [7:0]  skip;
    logic [7:0]  run1;
    logic [7:0]  run2;
    logic        is_tick;

    // Write data, byte writes zero-extended
    assign wdata = (i_item.access_size == SIZE_BYTE) ?
                   {8'h00, i_item.write_data[7:0]} : i_item.write_data;

    // Port selection: from the offset for accesses, from the port field for events
    assign reg_port    = i_item.reg_offset[3:1];
    assign reg_port_ok = i_item.reg_offset[4] && ({1'b0, reg_port} < 4'(NUM_PORTS));
    assign evt_port_ok = {3'b000, i_item.port_number} < 4'(NUM_PORTS);
    assign sel_port3   = (i_item.kind == KIND_READ || i_item.kind == KIND_WRITE) ?
                         reg_port : {2'b00, i_item.port_number};
    assign pidx        = sel_port3[PORT_IW-1:0];
    assign pval        = r_port[pidx];

    // Any port reporting resume detect
    always_comb begin
        any_rd = 1'b0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            any_rd = any_rd | r_port[i][PRT_RD];
        end
    end

    // Port write: keep read-only bits, clear write-clear bits written as one
    always_comb begin
        pwr_v = wdata;
        if (!pval[PRT_CCS]) begin
            pwr_v[PRT_EN] = 1'b0;
        end
        pwr_keep = ((pval & PRT_READ_ONLY) | (pwr_v & ~PRT_READ_ONLY))
                   & ~(pwr_v & PRT_WRITE_CLEAR);
    end

    // Register read mux
    always_comb begin
        case (i_item.reg_offset)
            OFF_CMD:     rd_val = r_cmd;
            OFF_STS:     rd_val = r_sts;
            OFF_INTR:    rd_val = r_intr;
            OFF_FRNUM:   rd_val = {5'b00000, r_frnum};
            OFF_FLBASE0: rd_val = {r_flbase[15:12], 12'h000};
            OFF_FLBASE1: rd_val = r_flbase[31:16];
            OFF_SOF:     rd_val = {8'h00, r_sof};
            default:     rd_val = reg_port_ok ? pval : UNMAPPED_VALUE;
        endcase
    end

    // Tick: frames over the catch-up limit are skipped, the rest clamped
    assign skip = (i_item.elapsed_frames > r_limit) ? (i_item.elapsed_frames - r_limit) : 8'd0;
    assign run1 = (i_item.elapsed_frames > r_limit) ? r_limit : i_item.elapsed_frames;
    assign run2 = (run1 > MAX_TICK_FRAMES) ? MAX_TICK_FRAMES : run1;

    // Next state and result for the item in the input register
    always_comb begin
        n_cmd    = r_cmd;
        n_sts    = r_sts;
        n_sts2   = r_sts2;
        n_intr   = r_intr;
        n_frnum  = r_frnum;
        n_flbase = r_flbase;
        n_sof    = r_sof;
        n_pend   = r_pend;
        for (int i = 0; i < NUM_PORTS; i++) begin
            n_port[i] = r_port[i];
        end
        o_res = '0;

        case (i_item.kind)
            KIND_READ: begin
                o_res.read_data = (i_item.access_size == SIZE_BYTE) ?
                                  {8'h00, rd_val[7:0]} : rd_val;
            end
            KIND_WRITE: begin
                case (i_item.reg_offset)
                    OFF_CMD: begin
                        if (wdata[CMD_RS] && !r_cmd[CMD_RS]) begin
                            n_sts[STS_HALTED] = 1'b0;
                        end else if (!wdata[CMD_RS]) begin
                            n_sts[STS_HALTED] = 1'b1;
                        end
                        if (wdata[CMD_GRESET] || wdata[CMD_HCRESET]) begin
                            // controller reset, ports and frame number kept
                            n_cmd    = '0;
                            n_sts    = STS_RESET;
                            n_sts2   = 1'b0;
                            n_intr   = '0;
                            n_flbase = '0;
                            n_sof    = SOF_RESET;
                            o_res.result_code = RC_RESET;
                            o_res.irq_pulse   = 1'b1;
                        end else begin
                            n_cmd = wdata;
                            if (wdata[CMD_EGSM] && any_rd) begin
                                n_cmd[CMD_FGR]   = 1'b1;
                                n_sts[STS_RD]    = 1'b1;
                                o_res.irq_pulse  = 1'b1;
                            end
                        end
                    end
                    OFF_STS: begin
                        n_sts = r_sts & ~wdata;
                        if (wdata[STS_USBINT]) begin
                            n_sts2 = 1'b0;
                        end
                        o_res.irq_pulse = 1'b1;
                    end
                    OFF_INTR: begin
                        n_intr = wdata;
                        o_res.irq_pulse = 1'b1;
                    end
                    OFF_FRNUM: begin
                        if (r_sts[STS_HALTED]) begin
                            n_frnum = wdata[10:0];
                        end
                    end
                    OFF_FLBASE0: n_flbase[15:12] = wdata[15:12];
                    OFF_FLBASE1: n_flbase[31:16] = wdata;
                    OFF_SOF:     n_sof = wdata[7:0];
                    default: begin
                        if (i_item.reg_offset[4]) begin
                            if (reg_port_ok) begin
                                n_port[pidx] = pwr_keep;
                            end else begin
                                o_res.result_code = RC_BAD_PORT;
                            end
                        end
                    end
                endcase
            end
            KIND_ATTACH, KIND_DETACH: begin
                if (!evt_port_ok) begin
                    o_res.result_code = RC_BAD_PORT;
                end else begin
                    if (i_item.kind == KIND_ATTACH) begin
                        n_port[pidx][PRT_CCS]  = 1'b1;
                        n_port[pidx][PRT_CSC]  = 1'b1;
                        n_port[pidx][PRT_LSDA] = i_item.low_speed;
                    end else begin
                        if (pval[PRT_CCS]) begin
                            n_port[pidx][PRT_CCS] = 1'b0;
                            n_port[pidx][PRT_CSC] = 1'b1;
                        end
                        if (pval[PRT_EN]) begin
                            n_port[pidx][PRT_EN]  = 1'b0;
                            n_port[pidx][PRT_ENC] = 1'b1;
                        end
                    end
                    // global resume
                    n_cmd[CMD_FGR]  = 1'b1;
                    n_sts[STS_RD]   = 1'b1;
                    o_res.irq_pulse = 1'b1;
                end
            end
            KIND_TICK: begin
                if (!r_cmd[CMD_RS]) begin
                    n_sts[STS_HALTED] = 1'b1;
                end else begin
                    n_frnum = r_frnum + 11'(skip) + 11'(run2);
                    if (r_pend) begin
                        n_sts2 = 1'b1;
                        n_sts[STS_USBINT] = 1'b1;
                        o_res.irq_pulse   = 1'b1;
                    end
                    n_pend = 1'b0;
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    // Catch-up limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Controller state, updated as each item passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= '0;
            r_sts    <= STS_RESET;
            r_sts2   <= 1'b0;
            r_intr   <= '0;
            r_frnum  <= '0;
            r_flbase <= '0;
            r_sof    <= SOF_RESET;
            r_pend   <= 1'b1;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_port[i] <= PORT_RESET;
            end
        end else if (i_adv) begin
            r_cmd    <= n_cmd;
            r_sts    <= n_sts;
            r_sts2   <= n_sts2;
            r_intr   <= n_intr;
            r_frnum  <= n_frnum;
            r_flbase <= n_flbase;
            r_sof    <= n_sof;
            r_pend   <= n_pend;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_port[i] <= n_port[i];
            end
        end
    end

    assign is_tick = (i_item.kind == KIND_TICK);

    // Frame number moves only on a tick or a write
    `UHCR_ASSERT(a_frnum_src, $past(i_rst_n) && (r_frnum != $past(r_frnum)) |-> $past(i_adv && (is_tick || i_item.kind == KIND_WRITE)), "frame number changed without tick or write")
    // A tick while stopped leaves the controller halted
    `UHCR_ASSERT(a_tick_halt, i_adv && is_tick && !r_cmd[CMD_RS] |=> r_sts[STS_HALTED], "tick while stopped did not halt")

endmodule

### design/uhcr_out_stage.sv
// Result register: holds one result item until the receiver takes it
module uhcr_out_stage import uhcr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_stall,
    input  t_result i_res,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/usb_host_controller_registers.sv
// Register block of a UHCI-style USB host controller: register reads and writes,
// port attach and detach, and frame ticks, one item per clock while the input does
// not stall. An accepted item is held in an input register and goes through the
// register file's combinational update logic. Its result is loaded into the result
// register when the held item advances, that is while the result register is empty
// or the receiver takes it. A new item is accepted every cycle while the receiver
// keeps up. When the result register is full and the receiver stalls, a held item
// cannot move on, so the input stalls in that same cycle. Each item is one
// read-modify-write of the controller registers, so throughput is set by that
// one update path. The user must write the catch-up frame limit through the
// configuration port only while no item is in flight; the block does not enforce it.
module usb_host_controller_registers import uhcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [4:0]  i_reg_offset,
    input  logic [1:0]  i_access_size,
    input  logic [15:0] i_write_data,
    input  logic        i_port_number,
    input  logic        i_low_speed,
    input  logic [7:0]  i_elapsed_frames,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_data,
    output logic [1:0]  o_result_code,
    output logic        o_irq_pulse
);

`include "assert_macros.svh"

    t_item   in_item;
    t_item   held_item;
    t_result core_res;
    t_result out_res;
    logic    held_valid;
    logic    adv;
    logic    accept;

    // Pipeline control: the held item moves on when the result register is free
    assign adv     = held_valid && (!o_valid || !i_stall);
    assign o_stall = held_valid && !adv;
    assign accept  = i_valid && !o_stall;

    assign in_item = '{kind:           i_kind,
                       reg_offset:     i_reg_offset,
                       access_size:    i_access_size,
                       write_data:     i_write_data,
                       port_number:    i_port_number,
                       low_speed:      i_low_speed,
                       elapsed_frames: i_elapsed_frames};

    uhcr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_adv   (adv),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    uhcr_regfile u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_item     (held_item),
        .o_res      (core_res)
    );

    uhcr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_stall (i_stall),
        .i_res   (core_res),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_read_data   = out_res.read_data;
    assign o_result_code = out_res.result_code;
    assign o_irq_pulse   = out_res.irq_pulse;

    // An empty result register never holds back the input side
    `UHCR_ASSERT_ALWAYS(a_no_false_stall, !o_valid |-> !o_stall, "input stalled with empty result register")
    // A controller reset always comes with an interrupt
    `UHCR_ASSERT(a_reset_irq, o_valid && (o_result_code == RC_RESET) |-> o_irq_pulse, "controller reset without interrupt")

endmodule

### bench/tb_usb_host_controller_registers.sv
// Self-checking testbench for the host controller register block
`timescale 1ns / 100ps

module tb_usb_host_controller_registers;
    import uhcr_pkg::*;

    // Codes the package leaves out
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_ODD  = 2'd3;
    localparam logic [2:0] KIND_NONE_LO = 3'd5;
    localparam logic [2:0] KIND_NONE_HI = 3'd7;
    localparam logic [4:0] OFF_ODD         = 5'h03;
    localparam logic [4:0] OFF_HOLE        = 5'h0e;
    localparam logic [4:0] OFF_PORT0       = 5'h10;
    localparam logic [4:0] OFF_PORT0_ALIAS = 5'h11;
    localparam logic [4:0] OFF_PORT1       = 5'h12;
    localparam logic [4:0] OFF_PORT2       = 5'h14;
    localparam logic [4:0] OFF_PORT3       = 5'h16;

    localparam int ITEMS_PER_PHASE = 188;
    localparam int PHASES          = 6;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DIRECTED_ROWS   = 26;

    // Directed row: item, and the reply when it is obvious
    typedef struct packed {
        t_item   item;
        logic    has_reply;
        t_result reply;
    } t_row;

    localparam t_result PREDICT = '0;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // DUT connections
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_kind = '0;
    logic [4:0]  i_reg_offset = '0;
    logic [1:0]  i_access_size = '0;
    logic [15:0] i_write_data = '0;
    logic        i_port_number = 1'b0;
    logic        i_low_speed = 1'b0;
    logic [7:0]  i_elapsed_frames = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_read_data;
    logic [1:0]  o_result_code;
    logic        o_irq_pulse;

    usb_host_controller_registers dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_reg_offset    (i_reg_offset),
        .i_access_size   (i_access_size),
        .i_write_data    (i_write_data),
        .i_port_number   (i_port_number),
        .i_low_speed     (i_low_speed),
        .i_elapsed_frames(i_elapsed_frames),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_data     (o_read_data),
        .o_result_code   (o_result_code),
        .o_irq_pulse     (o_irq_pulse)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the controller registers
    logic [15:0] hc_cmd, hc_sts, hc_intr;
    logic [7:0]  hc_sts2, hc_sof, hc_pending, hc_catchup;
    logic [10:0] hc_frnum;
    logic [31:0] hc_flbase;
    logic [15:0] hc_port [NUM_PORTS];

    t_result replies_due[$];
    int      fault_count = 0;
    int      burst_left  = 0;

    logic [4:0] mapped_offsets [10] = '{OFF_CMD, OFF_STS, OFF_INTR, OFF_FRNUM, OFF_FLBASE0,
                                        OFF_FLBASE1, OFF_SOF, OFF_PORT0, OFF_PORT1,
                                        OFF_PORT0_ALIAS};

    // Directed items: extremes, every kind, unmapped and bad-port cases, resets
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{'{KIND_READ, OFF_CMD, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0000, RC_OK, 1'b0}},
        '{'{KIND_READ, OFF_STS, SIZE_HALF, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0020, RC_OK, 1'b0}},
        '{'{KIND_READ, OFF_SOF, SIZE_BYTE, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0040, RC_OK, 1'b0}},
        '{'{KIND_READ, OFF_PORT0, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0080, RC_OK, 1'b0}},
        '{'{KIND_READ, OFF_HOLE, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'hff7f, RC_OK, 1'b0}},
        '{'{KIND_READ, OFF_ODD, SIZE_BYTE, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h007f, RC_OK, 1'b0}},
        '{'{KIND_READ, OFF_PORT2, SIZE_ODD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'hff7f, RC_OK, 1'b0}},
        '{'{KIND_WRITE, OFF_PORT3, SIZE_WORD, 16'hffff, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0000, RC_BAD_PORT, 1'b0}},
        '{'{KIND_WRITE, OFF_HOLE, SIZE_WORD, 16'hffff, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0000, RC_OK, 1'b0}},
        '{'{KIND_WRITE, OFF_FRNUM, SIZE_WORD, 16'hffff, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_ATTACH, OFF_CMD, SIZE_WORD, 16'h0000, 1'b0, 1'b1, 8'd0}, 1'b1,
          '{16'h0000, RC_OK, 1'b1}},
        '{'{KIND_WRITE, OFF_PORT0_ALIAS, SIZE_WORD, 16'hfe46, 1'b0, 1'b0, 8'd0}, 1'b0,
          PREDICT},
        '{'{KIND_READ, OFF_PORT0, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_WRITE, OFF_CMD, SIZE_BYTE, 16'hff09, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_TICK, OFF_CMD, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd255}, 1'b0, PREDICT},
        '{'{KIND_READ, OFF_FRNUM, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_WRITE, OFF_STS, SIZE_WORD, 16'hffff, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0000, RC_OK, 1'b1}},
        '{'{KIND_WRITE, OFF_INTR, SIZE_BYTE, 16'hffff, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_WRITE, OFF_FLBASE0, SIZE_WORD, 16'hffff, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_READ, OFF_FLBASE0, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_DETACH, OFF_CMD, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd0}, 1'b0, PREDICT},
        '{'{KIND_WRITE, OFF_CMD, SIZE_WORD, 16'h0002, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0000, RC_RESET, 1'b1}},
        '{'{KIND_WRITE, OFF_CMD, SIZE_BYTE, 16'hff04, 1'b0, 1'b0, 8'd0}, 1'b1,
          '{16'h0000, RC_RESET, 1'b1}},
        '{'{KIND_TICK, OFF_CMD, SIZE_WORD, 16'h0000, 1'b0, 1'b0, 8'd8}, 1'b1,
          '{16'h0000, RC_OK, 1'b0}},
        '{'{KIND_NONE_LO, OFF_PORT0, SIZE_WORD, 16'hffff, 1'b1, 1'b1, 8'd255}, 1'b1,
          '{16'h0000, RC_OK, 1'b0}},
        '{'{KIND_NONE_HI, OFF_STS, SIZE_BYTE, 16'hffff, 1'b1, 1'b1, 8'd255}, 1'b1,
          '{16'h0000, RC_OK, 1'b0}}
    };

    // Controller reset: ports, frame number and pending interrupts survive
    function automatic void clear_controller();
        hc_cmd    = '0;
        hc_sts    = STS_RESET;
        hc_sts2   = '0;
        hc_intr   = '0;
        hc_flbase = '0;
        hc_sof    = SOF_RESET;
    endfunction

    // Apply one item to the shadow registers and return its reply
    function automatic t_result predict_reply(input t_item it);
        t_result     r;
        logic [15:0] val;
        logic [15:0] pc;
        logic [2:0]  pn;
        logic [7:0]  frames;
        logic        any_rd;
        r   = '0;
        val = (it.access_size == SIZE_BYTE) ? {8'h00, it.write_data[7:0]} : it.write_data;
        pn  = it.reg_offset[3:1];
        case (it.kind)
            KIND_READ: begin
                case (it.reg_offset)
                    OFF_CMD:     r.read_data = hc_cmd;
                    OFF_STS:     r.read_data = hc_sts;
                    OFF_INTR:    r.read_data = hc_intr;
                    OFF_FRNUM:   r.read_data = {5'd0, hc_frnum};
                    OFF_FLBASE0: r.read_data = hc_flbase[15:0];
                    OFF_FLBASE1: r.read_data = hc_flbase[31:16];
                    OFF_SOF:     r.read_data = {8'd0, hc_sof};
                    default: begin
                        // port window also decodes odd offsets
                        if (it.reg_offset[4] && pn < NUM_PORTS)
                            r.read_data = hc_port[pn];
                        else
                            r.read_data = UNMAPPED_VALUE;
                    end
                endcase
                if (it.access_size == SIZE_BYTE)
                    r.read_data[15:8] = '0;
            end
            KIND_WRITE: begin
                case (it.reg_offset)
                    OFF_CMD: begin
                        if (val[CMD_RS] && !hc_cmd[CMD_RS])
                            hc_sts[STS_HALTED] = 1'b0;
                        else if (!val[CMD_RS])
                            hc_sts[STS_HALTED] = 1'b1;
                        if (val[CMD_GRESET] || val[CMD_HCRESET]) begin
                            clear_controller();
                            r.result_code = RC_RESET;
                            r.irq_pulse   = 1'b1;
                        end else begin
                            hc_cmd = val;
                            any_rd = 1'b0;
                            for (int i = 0; i < NUM_PORTS; i++)
                                if (hc_port[i][PRT_RD])
                                    any_rd = 1'b1;
                            // global resume
                            if (val[CMD_EGSM] && any_rd) begin
                                hc_cmd[CMD_FGR]   = 1'b1;
                                hc_sts[STS_RD]    = 1'b1;
                                r.irq_pulse       = 1'b1;
                            end
                        end
                    end
                    OFF_STS: begin
                        hc_sts = hc_sts & ~val;
                        if (val[STS_USBINT])
                            hc_sts2 = '0;
                        r.irq_pulse = 1'b1;
                    end
                    OFF_INTR: begin
                        hc_intr     = val;
                        r.irq_pulse = 1'b1;
                    end
                    OFF_FRNUM: begin
                        if (hc_sts[STS_HALTED])
                            hc_frnum = val[10:0];
                    end
                    OFF_FLBASE0: hc_flbase[15:0]  = {val[15:12], 12'h000};
                    OFF_FLBASE1: hc_flbase[31:16] = val;
                    OFF_SOF:     hc_sof = val[7:0];
                    default: begin
                        if (it.reg_offset[4]) begin
                            if (pn >= NUM_PORTS) begin
                                r.result_code = RC_BAD_PORT;
                            end else begin
                                // keep read-only bits, enable needs a connection
                                pc = hc_port[pn] & PRT_READ_ONLY;
                                if (!pc[PRT_CCS])
                                    val[PRT_EN] = 1'b0;
                                pc = pc | (val & ~PRT_READ_ONLY);
                                pc = pc & ~(val & PRT_WRITE_CLEAR);
                                hc_port[pn] = pc;
                            end
                        end
                    end
                endcase
            end
            KIND_ATTACH, KIND_DETACH: begin
                pc = hc_port[it.port_number];
                if (it.kind == KIND_ATTACH) begin
                    pc[PRT_CCS]  = 1'b1;
                    pc[PRT_CSC]  = 1'b1;
                    pc[PRT_LSDA] = it.low_speed;
                end else begin
                    if (pc[PRT_CCS]) begin
                        pc[PRT_CCS] = 1'b0;
                        pc[PRT_CSC] = 1'b1;
                    end
                    if (pc[PRT_EN]) begin
                        pc[PRT_EN]  = 1'b0;
                        pc[PRT_ENC] = 1'b1;
                    end
                end
                hc_port[it.port_number] = pc;
                hc_cmd[CMD_FGR] = 1'b1;
                hc_sts[STS_RD]  = 1'b1;
                r.irq_pulse     = 1'b1;
            end
            KIND_TICK: begin
                if (!hc_cmd[CMD_RS]) begin
                    hc_sts[STS_HALTED] = 1'b1;
                end else begin
                    // frames past the catch-up limit are skipped, the rest clamped
                    frames = it.elapsed_frames;
                    if (frames > hc_catchup) begin
                        hc_frnum = hc_frnum + {3'b000, frames - hc_catchup};
                        frames   = hc_catchup;
                    end
                    if (frames > MAX_TICK_FRAMES)
                        frames = MAX_TICK_FRAMES;
                    hc_frnum = hc_frnum + {3'b000, frames};
                    if (hc_pending != '0) begin
                        hc_sts2            = hc_sts2 | hc_pending;
                        hc_sts[STS_USBINT] = 1'b1;
                        r.irq_pulse        = 1'b1;
                    end
                    hc_pending = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one item in a burst pattern, record its reply once accepted
    task automatic send_item(input t_item it, input logic has_reply, input t_result reply);
        t_result predicted;
        int      gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_kind           <= it.kind;
        i_reg_offset     <= it.reg_offset;
        i_access_size    <= it.access_size;
        i_write_data     <= it.write_data;
        i_port_number    <= it.port_number;
        i_low_speed      <= it.low_speed;
        i_elapsed_frames <= it.elapsed_frames;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predicted = predict_reply(it);
        replies_due.push_back(has_reply ? reply : predicted);
    endtask

    // Drop valid and wait for every outstanding reply
    task automatic drain_replies();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_catchup_limit(input logic [7:0] frames);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= frames;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        hc_catchup = frames;
    endtask

    // Compare one accepted reply with the oldest one due
    task automatic check_reply(input t_result got);
        t_result want;
        if (replies_due.size() == 0) begin
            $display("%0t: reply with no item outstanding: data %h code %0d irq %0b",
                     $time, got.read_data, got.result_code, got.irq_pulse);
            fault_count++;
        end else begin
            want = replies_due.pop_front();
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data expected %h got %h",
                         $time, want.read_data, got.read_data);
                fault_count++;
            end
            if (got.result_code !== want.result_code) begin
                $display("%0t: result_code expected %0d got %0d",
                         $time, want.result_code, got.result_code);
                fault_count++;
            end
            if (got.irq_pulse !== want.irq_pulse) begin
                $display("%0t: irq_pulse expected %0b got %0b",
                         $time, want.irq_pulse, got.irq_pulse);
                fault_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_reply({o_read_data, o_result_code, o_irq_pulse});
    end

    // Receiver stall pattern: free, light, heavy and periodic stretches
    t_rx_mode rx_mode = RX_FREE;
    int       rx_mode_left = 0;

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 96);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
            default:  i_stall <= (rx_mode_left % 3 == 0);
        endcase
    end

    // Ends the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_usb_host_controller_registers: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_item      it;
        logic [7:0] frames;
        int         pick;
        // shadow state after power-up reset
        clear_controller();
        hc_catchup = '0;
        hc_frnum   = '0;
        hc_pending = 8'd1;
        for (int i = 0; i < NUM_PORTS; i++)
            hc_port[i] = PORT_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_catchup_limit(8'd0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].has_reply,
                      directed_rows[i].reply);
        drain_replies();

        // Random phases, each under its own catch-up limit
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       frames = 8'd255;
                1:       frames = 8'd1;
                2:       frames = MAX_TICK_FRAMES;
                3:       frames = MAX_TICK_FRAMES + 8'd1;
                default: frames = 8'($urandom_range(0, 255));
            endcase
            write_catchup_limit(frames);
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    it.kind = KIND_READ;
                else if (pick < 70)
                    it.kind = KIND_WRITE;
                else if (pick < 78)
                    it.kind = KIND_ATTACH;
                else if (pick < 86)
                    it.kind = KIND_DETACH;
                else if (pick < 98)
                    it.kind = KIND_TICK;
                else
                    it.kind = 3'($urandom_range(KIND_NONE_LO, KIND_NONE_HI));
                it.reg_offset = ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                            : mapped_offsets[$urandom_range(0, 9)];
                it.access_size = 2'($urandom);
                it.write_data  = 16'($urandom);
                // keep controller resets rare and the run bit mostly set
                if (it.kind == KIND_WRITE && it.reg_offset == OFF_CMD) begin
                    if ($urandom_range(0, 11) != 0) begin
                        it.write_data[CMD_HCRESET] = 1'b0;
                        it.write_data[CMD_GRESET]  = 1'b0;
                    end
                    if ($urandom_range(0, 3) != 0)
                        it.write_data[CMD_RS] = 1'b1;
                end
                it.port_number    = 1'($urandom);
                it.low_speed      = 1'($urandom);
                it.elapsed_frames = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40))
                                                                : 8'($urandom);
                send_item(it, 1'b0, PREDICT);
            end
            drain_replies();
        end

        // catch any stray reply
        repeat (8) @(posedge i_clk);
        if (fault_count == 0)
            $display("tb_usb_host_controller_registers: PASS");
        else
            $display("tb_usb_host_controller_registers: FAIL");
        $finish;
    end

endmodule
